@@ rtl/core/trd_pkg.sv @@
// Shared types, constants and the terrain palette for the terrain RLE run decoder.
package trd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTROL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_LITERAL = 2'd3
    } t_phase;

    // Configuration register indexes.
    localparam logic CFG_HEADER_BYTES = 1'b0;
    localparam logic CFG_FRAME_PIXELS = 1'b1;

    localparam logic [3:0]  HEADER_BYTES_RESET = 4'd2;
    localparam logic [15:0] FRAME_PIXELS_RESET = 16'd19200;  // 240 * 80 tiles

    localparam logic [7:0] CTRL_SKIP       = 8'h00;
    localparam logic [7:0] CTRL_SINGLE     = 8'h01;
    localparam logic [8:0] REPEAT_BASE     = 9'h101;

    // One decoded run handed from the phase machine to the output stage.
    typedef struct packed {
        logic       emit;
        logic [7:0] code;
        logic [7:0] run;
    } t_run;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic t_rgb palette(input logic [2:0] code);
        t_rgb c;
        case (code)
            3'd0:    c = '{red: 8'd32,  green: 8'd128, blue: 8'd32};
            3'd1:    c = '{red: 8'd64,  green: 8'd192, blue: 8'd64};
            3'd2:    c = '{red: 8'd255, green: 8'd255, blue: 8'd192};
            3'd3:    c = '{red: 8'd32,  green: 8'd32,  blue: 8'd192};
            3'd4:    c = '{red: 8'd48,  green: 8'd160, blue: 8'd48};
            3'd5:    c = '{red: 8'd64,  green: 8'd192, blue: 8'd64};
            3'd6:    c = '{red: 8'd80,  green: 8'd224, blue: 8'd80};
            default: c = '{red: 8'd128, green: 8'd128, blue: 8'd128};
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/trd_decode.sv @@
// Phase machine that skips the header and splits control, repeat and literal bytes.
module trd_decode import trd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_header,
    output t_run       o_run
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_header_bytes;
    logic [3:0] r_header_left, n_header_left;
    logic [7:0] r_pending, n_pending;
    logic [6:0] r_literals, n_literals;

    t_phase     e_phase;
    logic [3:0] e_header_left;
    logic [7:0] e_pending;
    logic [6:0] e_literals;

    // A stream start clears the run in progress before this byte is handled.
    assign e_phase       = i_start ? PH_HEADER : r_phase;
    assign e_header_left = i_start ? r_header_bytes : r_header_left;
    assign e_pending     = i_start ? 8'd0 : r_pending;
    assign e_literals    = i_start ? 7'd0 : r_literals;

    // Next state.
    always_comb begin
        logic ctrl;
        n_phase       = e_phase;
        n_header_left = e_header_left;
        n_pending     = e_pending;
        n_literals    = e_literals;
        ctrl          = 1'b0;
        case (e_phase)
            PH_HEADER: begin
                if (e_header_left != 4'd0) begin
                    n_header_left = e_header_left - 4'd1;
                    if (e_header_left == 4'd1) begin
                        n_phase = PH_CONTROL;
                    end
                end else begin
                    // With no header left the byte is already a control byte.
                    ctrl = 1'b1;
                end
            end
            PH_CONTROL: begin
                ctrl = 1'b1;
            end
            PH_REPEAT: begin
                n_pending = 8'd0;
                n_phase   = PH_CONTROL;
            end
            PH_LITERAL: begin
                if (e_literals != 7'd0) begin
                    n_literals = e_literals - 7'd1;
                end
                if (e_literals <= 7'd1) begin
                    n_phase = PH_CONTROL;
                end
            end
            default: begin
                n_phase = PH_CONTROL;
            end
        endcase
        if (ctrl) begin
            n_phase = PH_CONTROL;
            if (i_byte == CTRL_SKIP) begin
                n_phase = PH_CONTROL;
            end else if (i_byte == CTRL_SINGLE || i_byte[7]) begin
                n_pending = (i_byte == CTRL_SINGLE) ? 8'd1
                                                    : 8'(REPEAT_BASE - {1'b0, i_byte});
                n_phase   = PH_REPEAT;
            end else begin
                n_literals = i_byte[6:0];
                n_phase    = PH_LITERAL;
            end
        end
    end

    // Outputs.
    always_comb begin
        o_run.code = i_byte;
        case (e_phase)
            PH_REPEAT: begin
                o_run.emit = 1'b1;
                o_run.run  = e_pending;
            end
            PH_LITERAL: begin
                o_run.emit = 1'b1;
                o_run.run  = 8'd1;
            end
            default: begin
                o_run.emit = 1'b0;
                o_run.run  = 8'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_bytes <= HEADER_BYTES_RESET;
            r_header_left  <= HEADER_BYTES_RESET;
            r_pending      <= 8'd0;
            r_literals     <= 7'd0;
        end else begin
            if (i_cfg_we) begin
                r_header_bytes <= i_cfg_header;
            end
            if (i_fire) begin
                r_phase       <= n_phase;
                r_header_left <= n_header_left;
                r_pending     <= n_pending;
                r_literals    <= n_literals;
            end else if (i_cfg_we && r_phase == PH_HEADER) begin
                // A new header length restarts a skip that is under way.
                r_header_left <= i_cfg_header;
            end
        end
    end

endmodule

@@ rtl/core/trd_emit.sv @@
// Output stage: palette lookup, tile count and the result register.
module trd_emit import trd_pkg::*; #(
    parameter int PIXEL_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic        i_start,
    input  t_run        i_run,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_frame,
    input  logic        i_out_stall,
    output logic        o_room,
    output logic        o_out_valid,
    output logic [2:0]  o_terrain,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_run_length,
    output logic        o_frame_done,
    output logic        o_bad_terrain
);

    localparam int SUM_W = PIXEL_COUNT_BITS + 1;
    localparam int CMP_W = (SUM_W > 16) ? SUM_W : 16;

    logic [PIXEL_COUNT_BITS-1:0] r_count, n_count, e_count;
    logic [15:0]                 r_frame;
    logic [SUM_W-1:0]            sum;
    logic                        bad, done, load;
    logic [2:0]                  code;
    t_rgb                        rgb;

    assign e_count = i_start ? '0 : r_count;
    assign sum     = {1'b0, e_count} + SUM_W'(i_run.run);
    assign done    = CMP_W'(sum) >= CMP_W'(r_frame);
    assign bad     = |i_run.code[7:3];
    assign code    = bad ? 3'd0 : i_run.code[2:0];
    assign rgb     = palette(code);
    assign o_room  = !o_out_valid || !i_out_stall;
    assign load    = i_fire && i_run.emit;

    always_comb begin
        if (done) begin
            n_count = '0;
        end else if (sum[SUM_W-1]) begin
            n_count = '1;
        end else begin
            n_count = sum[PIXEL_COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_frame     <= FRAME_PIXELS_RESET;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame <= i_cfg_frame;
            end
            if (load) begin
                r_count <= n_count;
            end else if (i_fire) begin
                r_count <= e_count;
            end
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_terrain     <= code;
            o_red         <= bad ? 8'd0 : rgb.red;
            o_green       <= bad ? 8'd0 : rgb.green;
            o_blue        <= bad ? 8'd0 : rgb.blue;
            o_run_length  <= i_run.run;
            o_frame_done  <= done;
            o_bad_terrain <= bad;
        end
    end

endmodule

@@ rtl/core/terrain_rle_run_decoder.sv @@
// Top level of the terrain RLE run decoder: input register, configuration and stages.
//
// Input channel: one compressed map byte per beat (i_in_byte), with i_stream_start
// marking the first byte of a new stream. A beat is taken when i_in_valid is high
// and o_in_stall is low. Output channel: one run per beat (terrain code, palette
// colour, run length, frame end and bad-code flags), taken when o_out_valid is high
// and i_out_stall is low. Header, control and repeat-count bytes give no result.
// A byte waits in the input register and its run is loaded into the result register
// as it moves on. Throughput is one byte per cycle unless a run waits on a stalled
// receiver; the phase machine and tile counter update together. When the receiver
// stalls, the result register holds its run and the input register still moves
// bytes that produce no run; a byte that produces a run waits there and o_in_stall
// rises until the result register frees up. Configuration writes (o_cfg_ready is
// always high) are the user's to make only while the block is idle; the block does
// not enforce this. Synchronous reset restores a two-byte header skip, 19200 tiles
// per frame, the header phase and a zero tile count, and empties both registers.
module terrain_rle_run_decoder import trd_pkg::*; #(
    parameter int PIXEL_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_stream_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_terrain,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_run_length,
    output logic        o_frame_done,
    output logic        o_bad_terrain,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       accept, fire, room;
    logic       cfg_we_header, cfg_we_frame;
    t_run       run;

    assign o_cfg_ready   = 1'b1;
    assign cfg_we_header = i_cfg_valid && i_cfg_index == CFG_HEADER_BYTES;
    assign cfg_we_frame  = i_cfg_valid && i_cfg_index == CFG_FRAME_PIXELS;

    // A held byte moves on unless it makes a run and the result register is full.
    assign fire       = r_in_valid && (!run.emit || room);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_stream_start;
        end
    end

    trd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .i_start      (r_in_start),
        .i_cfg_we     (cfg_we_header),
        .i_cfg_header (i_cfg_data[3:0]),
        .o_run        (run)
    );

    trd_emit #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_start       (r_in_start),
        .i_run         (run),
        .i_cfg_we      (cfg_we_frame),
        .i_cfg_frame   (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_room        (room),
        .o_out_valid   (o_out_valid),
        .o_terrain     (o_terrain),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_run_length  (o_run_length),
        .o_frame_done  (o_frame_done),
        .o_bad_terrain (o_bad_terrain)
    );

endmodule
